// File: rtl/llrr_pkg.sv
// Shared types and constants for the least-loaded round-robin scheduler.
// No dependencies.
`default_nettype none
package llrr_pkg;

	localparam int MAX_CORES_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic       OP_ADD = 1'b0;
	localparam logic       OP_RUN = 1'b1;

	localparam logic [1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [1:0] KIND_ADD_DROP = 2'd1;
	localparam logic [1:0] KIND_RAN      = 2'd2;
	localparam logic [1:0] KIND_IDLE     = 2'd3;

	typedef struct packed {
		logic       operation;
		logic [7:0] process_id;
		logic [7:0] thread_id;
		logic [7:0] time_slots;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] core_index;
		logic [7:0] ran_process;
		logic [7:0] ran_thread;
		logic       finished;
		logic       last_result;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic skip;
		logic add_commit;
		logic rd_issue;
		logic run_commit;
		logic emit_nocore;
		logic emit_idle;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_op;
		logic n_zero;
		logic scan_last;
		logic any_ready;
		logic cur_ready;
		logic run_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/least_loaded_round_robin_scheduler_top.sv
// Top level of the least-loaded round-robin scheduler.
// Depends on llrr_pkg, llrr_ctrl, llrr_dp (and llrr_ram below it).
//
// channel | signals                        | moves
// --------+--------------------------------+-------------------------------
// in      | in_valid, in_ready, in_data    | one add or run item
// out     | out_valid, out_ready, out_data | one result item
// cfg     | cfg_we, cfg_data               | active core count, no wait
//
// One item at a time. Add: a min-count scan over the active cores (clamped),
// one core a cycle, then an add result. Add with no cores: a drop result.
// Run with nothing queued: an idle result. Otherwise run: empty cores below
// the last busy one are skipped, and each busy core gets a store read and a
// result; cores above the last busy one are not visited.
// Reset clears heads, counts and the core register; the thread store is
// not cleared. A stalled output holds the next result back; the final
// result of an item sits in the output register while a new item is taken.
`default_nettype none
module least_loaded_round_robin_scheduler_top #(
	parameter int MAX_CORES   = llrr_pkg::MAX_CORES_DEF,
	parameter int QUEUE_DEPTH = llrr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  llrr_pkg::in_t   in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output llrr_pkg::out_t  out_data,
	input  wire             cfg_we,
	input  wire  [3:0]      cfg_data
);

	llrr_pkg::cmd_t    cmd;
	llrr_pkg::status_t sts;

	// controller: walks add scan and run visits
	llrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: queue state, thread store and result register
	llrr_dp #(
		.MAX_CORES   (MAX_CORES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/llrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module llrr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/llrr_ctrl.sv
// Sequencing state machine for the scheduler.
// Depends on llrr_pkg.
`default_nettype none
module llrr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  llrr_pkg::status_t   sts,
	output llrr_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_ADD, ST_NOCORE, ST_EMPTY, ST_RCHK, ST_RRD, ST_REMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.in_op == llrr_pkg::OP_RUN) begin
						state_d = sts.any_ready ? ST_RCHK : ST_EMPTY;
					end else begin
						state_d = sts.n_zero ? ST_NOCORE : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (sts.out_free) begin
					cmd.add_commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_NOCORE: begin
				if (sts.out_free) begin
					cmd.emit_nocore = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_idle = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RCHK: begin
				if (sts.cur_ready) begin
					cmd.rd_issue = 1'b1;
					state_d = ST_RRD;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			ST_RRD: begin
				state_d = ST_REMIT;
			end
			ST_REMIT: begin
				if (sts.out_free) begin
					cmd.run_commit = 1'b1;
					state_d = sts.run_last ? ST_IDLE : ST_RCHK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/llrr_dp.sv
// Datapath: queue heads and counts, thread store, core walk, result register.
// Depends on llrr_pkg and llrr_ram.
`default_nettype none
module llrr_dp #(
	parameter int MAX_CORES   = llrr_pkg::MAX_CORES_DEF,
	parameter int QUEUE_DEPTH = llrr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  llrr_pkg::cmd_t      cmd,
	output llrr_pkg::status_t   sts,
	input  llrr_pkg::in_t       in_data,
	input  wire                 cfg_we,
	input  wire  [3:0]          cfg_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output llrr_pkg::out_t      out_data
);

	localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW    = $clog2(MAX_CORES + 1);
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int QW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = MAX_CORES * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	logic [3:0]    active_q;
	logic [NW-1:0] ncores;
	logic [CW-1:0] core_q;
	logic [PW-1:0] head_q [MAX_CORES];
	logic [QW-1:0] cnt_q  [MAX_CORES];
	logic [CW-1:0] best_q;
	logic [QW-1:0] best_cnt_q;
	logic [PW-1:0] best_head_q;
	llrr_pkg::in_t item_q;
	llrr_pkg::out_t out_q;
	logic          out_valid_q;

	logic [MAX_CORES-1:0] ready_vec, above_vec;
	logic [PW-1:0] cur_head;
	logic [QW-1:0] cur_cnt;
	logic          out_free;

	assign ncores = (32'(active_q) > 32'(MAX_CORES)) ? NW'(MAX_CORES) : NW'(active_q);
	assign cur_head = head_q[core_q];
	assign cur_cnt  = cnt_q[core_q];

	for (genvar i = 0; i < MAX_CORES; i++) begin : g_vec
		assign ready_vec[i] = (cnt_q[i] != '0) && (NW'(i) < ncores);
		assign above_vec[i] = (CW'(i) > core_q);
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts           = '0;
		sts.in_op     = in_data.operation;
		sts.n_zero    = (ncores == '0);
		sts.scan_last = ((NW+1)'(core_q) + (NW+1)'(1) == (NW+1)'(ncores));
		sts.any_ready = |ready_vec;
		sts.cur_ready = ready_vec[core_q];
		sts.run_last  = ~|(ready_vec & above_vec);
		sts.out_free  = out_free;
	end

	// position = (head + count) mod depth, both below depth resp. at most depth
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] h, input logic [QW-1:0] c);
		logic [QW:0] s;
		s = (QW+1)'(h) + (QW+1)'(c);
		if (s >= (QW+1)'(QUEUE_DEPTH)) s = s - (QW+1)'(QUEUE_DEPTH);
		return PW'(s);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [PW-1:0] p);
		return AW'(AW'(c) * AW'(QUEUE_DEPTH)) + AW'(p);
	endfunction

	// thread store
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [23:0]   ram_wdata, ram_rdata;
	logic [7:0]    rd_pid, rd_tid, rd_slots, new_slots;
	logic          fin;
	logic [PW-1:0] head_next;

	assign {rd_pid, rd_tid, rd_slots} = ram_rdata;
	assign fin       = (rd_slots <= 8'd1);
	assign new_slots = (rd_slots == 8'd0) ? 8'd0 : rd_slots - 8'd1;
	assign head_next = (cur_head == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + PW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_of(core_q, wrap_add(cur_head, cur_cnt));
		ram_wdata = {rd_pid, rd_tid, new_slots};
		if (cmd.add_commit) begin
			ram_we    = (best_cnt_q < QW'(QUEUE_DEPTH));
			ram_waddr = addr_of(best_q, wrap_add(best_head_q, best_cnt_q));
			ram_wdata = {item_q.process_id, item_q.thread_id, item_q.time_slots};
		end else if (cmd.run_commit) begin
			ram_we = !fin;
		end
	end

	assign ram_re    = cmd.rd_issue;
	assign ram_raddr = addr_of(core_q, cur_head);

	llrr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			core_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CORES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) active_q <= cfg_data;
			if (cmd.accept) core_q <= '0;
			if (cmd.scan || cmd.skip) core_q <= core_q + CW'(1);
			if (cmd.add_commit && best_cnt_q < QW'(QUEUE_DEPTH)) begin
				cnt_q[best_q] <= best_cnt_q + QW'(1);
			end
			if (cmd.run_commit) begin
				core_q         <= core_q + CW'(1);
				head_q[core_q] <= head_next;
				if (fin) cnt_q[core_q] <= cur_cnt - QW'(1);
			end
			if (cmd.add_commit || cmd.run_commit || cmd.emit_nocore || cmd.emit_idle) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result fields: kind, core, pid, tid, finished, last
	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= in_data;
		if (cmd.scan && (core_q == '0 || cur_cnt < best_cnt_q)) begin
			best_q      <= core_q;
			best_cnt_q  <= cur_cnt;
			best_head_q <= cur_head;
		end
		if (cmd.add_commit) begin
			out_q <= {((best_cnt_q < QW'(QUEUE_DEPTH)) ?
				llrr_pkg::KIND_ADD_OK : llrr_pkg::KIND_ADD_DROP),
				3'(best_q), 8'd0, 8'd0, 1'b0, 1'b1};
		end else if (cmd.emit_nocore) begin
			out_q <= {llrr_pkg::KIND_ADD_DROP, 3'd0, 8'd0, 8'd0, 1'b0, 1'b1};
		end else if (cmd.emit_idle) begin
			out_q <= {llrr_pkg::KIND_IDLE, 3'd0, 8'd0, 8'd0, 1'b0, 1'b1};
		end else if (cmd.run_commit) begin
			out_q.kind        <= llrr_pkg::KIND_RAN;
			out_q.core_index  <= 3'(core_q);
			out_q.ran_process <= rd_pid;
			out_q.ran_thread  <= rd_tid;
			out_q.finished    <= fin;
			out_q.last_result <= sts.run_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the current core's queue never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt <= QW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// a core is only run when it holds a thread
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> cur_cnt != '0)
		else $error("read issued on empty queue");

	// every commit leaves a result waiting
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_commit || cmd.run_commit) |=> out_valid_q)
		else $error("commit without result");

	// commits never collide with a new item
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(cmd.add_commit || cmd.run_commit || cmd.scan))
		else $error("overlapping commands");

endmodule
`default_nettype wire
